// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a same-cycle implication at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");
// Check that an implication holds in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: src/dwt_pkg.sv
// ----------------------------------------------------------------------------
// dwt_pkg
// Shared types, constants and helpers of the daily window pulse timer.
// ----------------------------------------------------------------------------
package dwt_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgTicksPerSecond = 2'd0;
  localparam logic [1:0] CfgSprayInterval  = 2'd1;
  localparam logic [1:0] CfgWindowEnd      = 2'd2;

  // Calendar limits
  localparam logic [5:0]  SecondsPerMinute = 6'd60;
  localparam logic [11:0] MinutesPerDay    = 12'd1440;
  localparam logic [6:0]  InactiveCount    = 7'd99;

  // Reset values
  localparam logic [15:0] TicksPerSecondRst = 16'd61;
  localparam logic [6:0]  SprayIntervalRst  = 7'd22;
  localparam logic [10:0] WindowEndRst      = 11'd242;
  localparam logic [5:0]  SecondRst         = 6'd55;
  localparam logic [10:0] MinuteRst         = 11'd21;
  localparam logic [6:0]  PhaseRst          = 7'd21;

  // Time base view after one transaction has been applied
  typedef struct packed {
    logic        entered;
    logic [5:0]  second;
    logic [10:0] minute;
    logic [6:0]  phase;
  } dwt_time_t;

  // Status fields derived from the time base
  typedef struct packed {
    logic       spray_pulse;
    logic       active;
    logic [6:0] minutes_to_next;
    logic [7:0] display_bcd;
  } dwt_status_t;

  // Treat a zero interval as one minute
  function automatic logic [6:0] eff_interval(input logic [6:0] ivl);
    eff_interval = (ivl == 7'd0) ? 7'd1 : ivl;
  endfunction

  // Packed BCD of a value below 100; tens by reciprocal multiply (v*205)>>11
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  units;
    prod     = {8'd0, v} * 15'd205;
    tens     = prod[14:11];
    tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    units    = v - tens_x10;
    to_bcd   = {tens, units[3:0]};
  endfunction

endpackage

// File: src/dwt_timebase.sv
// ----------------------------------------------------------------------------
// dwt_timebase
// Tick prescaler, second and minute-of-day counters and the interval phase.
// ----------------------------------------------------------------------------
module dwt_timebase (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               tick,
  input  logic [15:0]        ticks_per_second,
  input  logic [6:0]         interval,
  output dwt_pkg::dwt_time_t time_nxt
);
  import dwt_pkg::*;

  logic [15:0] prescale_r, prescale_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [10:0] minute_r, minute_nxt;
  logic [6:0]  phase_r, phase_nxt;
  logic        entered;
  logic [5:0]  second_inc;
  logic [11:0] minute_inc;
  logic [7:0]  phase_inc;

  // Work out the counters after this tick
  always_comb begin
    prescale_nxt = prescale_r;
    second_inc   = second_r;
    second_nxt   = second_r;
    minute_nxt   = minute_r;
    phase_nxt    = phase_r;
    entered      = 1'b0;
    minute_inc   = {1'b0, minute_r} + 12'd1;
    phase_inc    = {1'b0, phase_r} + 8'd1;
    if (tick) begin
      if (prescale_r >= ticks_per_second) begin
        prescale_nxt = 16'd1;
        second_inc   = second_r + 6'd1;
      end else begin
        prescale_nxt = prescale_r + 16'd1;
      end
      second_nxt = second_inc;
      if (second_inc >= SecondsPerMinute) begin
        second_nxt = 6'd0;
        entered    = 1'b1;
        if (minute_inc >= MinutesPerDay) begin
          minute_nxt = 11'd0;
          phase_nxt  = 7'd0;
        end else begin
          minute_nxt = minute_inc[10:0];
          if (phase_inc >= {1'b0, interval}) begin
            phase_nxt = 7'd0;
          end else begin
            phase_nxt = phase_inc[6:0];
          end
        end
      end
    end
  end

  // Hold state between transactions; load when one is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= 16'd0;
      second_r   <= SecondRst;
      minute_r   <= MinuteRst;
      phase_r    <= PhaseRst;
    end else if (advance) begin
      prescale_r <= prescale_nxt;
      second_r   <= second_nxt;
      minute_r   <= minute_nxt;
      phase_r    <= phase_nxt;
    end
  end

  assign time_nxt.entered = entered;
  assign time_nxt.second  = second_nxt;
  assign time_nxt.minute  = minute_nxt;
  assign time_nxt.phase   = phase_nxt;

endmodule

// File: src/dwt_status.sv
// ----------------------------------------------------------------------------
// dwt_status
// Active window, minutes to next spray, pulse and display byte.
// ----------------------------------------------------------------------------
module dwt_status (
  input  dwt_pkg::dwt_time_t   time_in,
  input  logic [6:0]           interval,
  input  logic [10:0]          window_end,
  output dwt_pkg::dwt_status_t status
);
  import dwt_pkg::*;

  logic       active;
  logic [6:0] to_next;
  logic [6:0] bcd_src;

  // Count down to the next spray while inside the window
  always_comb begin
    active = (time_in.minute <= window_end);
    if (!active) begin
      to_next = InactiveCount;
    end else if (time_in.phase >= interval) begin
      to_next = 7'd1;
    end else begin
      to_next = interval - time_in.phase;
    end
    bcd_src = active ? to_next : {1'b0, time_in.second};
  end

  assign status.spray_pulse     = time_in.entered && active && (time_in.phase == 7'd0);
  assign status.active          = active;
  assign status.minutes_to_next = to_next;
  assign status.display_bcd     = to_bcd(bcd_src);

endmodule

// File: src/daily_window_interval_pulse_timer_core.sv
// ----------------------------------------------------------------------------
// daily_window_interval_pulse_timer_core
// Path: a tick is held in the input register; the counters then advance and the
// status is captured in the result register that drives the out_ ports.
// Throughput: 1 transaction per cycle while the output is not stalled; an input
// register and a result register part the channels; counters load with results.
// Reset: synchronous, active low; restores counters and config registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module daily_window_interval_pulse_timer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_spray_pulse,
  output logic        out_active,
  output logic [6:0]  out_minutes_to_next,
  output logic [7:0]  out_display_bcd,
  output logic [5:0]  out_second_now,
  output logic [10:0] out_minute_now
);
  import dwt_pkg::*;

  logic [15:0] ticks_per_second_r;
  logic [6:0]  spray_interval_r;
  logic [10:0] window_end_r;
  logic [6:0]  interval;

  logic        s1_valid_r;
  logic        s1_tick_r;
  logic        s2_load;
  logic        out_valid_r;

  dwt_time_t   time_nxt;
  dwt_status_t status;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_second_r <= TicksPerSecondRst;
      spray_interval_r   <= SprayIntervalRst;
      window_end_r       <= WindowEndRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgTicksPerSecond: ticks_per_second_r <= cfg_wdata;
        CfgSprayInterval:  spray_interval_r   <= cfg_wdata[6:0];
        CfgWindowEnd:      window_end_r       <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  assign interval = eff_interval(spray_interval_r);

  // Advance the pipeline when the result register is free
  assign s2_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_tick_r <= in_tick;
    end
  end

  dwt_timebase u_timebase (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (s2_load),
    .tick             (s1_tick_r),
    .ticks_per_second (ticks_per_second_r),
    .interval         (interval),
    .time_nxt         (time_nxt)
  );

  dwt_status u_status (
    .time_in    (time_nxt),
    .interval   (interval),
    .window_end (window_end_r),
    .status     (status)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_spray_pulse     <= status.spray_pulse;
      out_active          <= status.active;
      out_minutes_to_next <= status.minutes_to_next;
      out_display_bcd     <= status.display_bcd;
      out_second_now      <= time_nxt.second;
      out_minute_now      <= time_nxt.minute;
    end
  end

  assign out_valid = out_valid_r;

  // A pulse only ever fires inside the window
  `ASSERT_IMPL(a_pulse_active, clk, rst_n, out_valid_r && out_spray_pulse, out_active)
  // Outside the window the countdown reads the inactive marker
  `ASSERT_IMPL(a_inactive_count, clk, rst_n, out_valid_r && !out_active,
               out_minutes_to_next == InactiveCount)
  // Seconds stay within the minute
  `ASSERT_IMPL(a_second_range, clk, rst_n, out_valid_r, out_second_now < SecondsPerMinute)
  // A held input transaction is not dropped while the output stalls
  `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !s2_load, s1_valid_r)

endmodule
